FILE: rtl/mm64_pkg.sv
`timescale 1ns / 1ps

package mm64_pkg;

    // Mixing multiplier and shift of the hash.
    localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT  = 47;
    localparam logic [63:0] SEED_RESET = 64'h00000000e17a1465;

    // Request to the shared multiplier: operand is multiplied by MIX_MUL.
    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } mul_req_t;

    // Answer of the shared multiplier: done pulses for one cycle with the product.
    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } mul_rsp_t;

endpackage

FILE: rtl/mm64_mul.sv
`timescale 1ns / 1ps

// Multiplies a 64-bit operand by the mixing constant, modulo 2^64, with one
// 32 by 32 multiplier. The low, then the two cross partial products are
// formed one per cycle; each product is registered before it is summed.
module mm64_mul
(
    input  logic                clk,
    input  logic                rst_n,
    input  mm64_pkg::mul_req_t  req,
    output mm64_pkg::mul_rsp_t  rsp
);

    localparam logic [31:0] MUL_LO = mm64_pkg::MIX_MUL[31:0];
    localparam logic [31:0] MUL_HI = mm64_pkg::MIX_MUL[63:32];

    logic        active_reg, active_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] result_reg, result_next;

    logic [31:0] opa;
    logic [31:0] opb;
    logic [63:0] product;

    always_comb
    begin
        case (cnt_reg)
            2'd1:
            begin
                opa = a_reg[63:32];
                opb = MUL_LO;
            end
            2'd2:
            begin
                opa = a_reg[31:0];
                opb = MUL_HI;
            end
            default:
            begin
                opa = a_reg[31:0];
                opb = MUL_LO;
            end
        endcase
    end

    assign product = 64'(opa) * 64'(opb);

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        a_next      = a_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        if (req.start)
        begin
            active_next = 1'b1;
            cnt_next    = 2'd0;
            a_next      = req.operand;
        end
        else if (active_reg)
        begin
            prod_next = product;
            cnt_next  = cnt_reg + 2'd1;
            case (cnt_reg)
                2'd1:    acc_next = prod_reg;
                2'd2:    acc_next = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                2'd3:
                begin
                    result_next = acc_reg + {prod_reg[31:0], 32'h0};
                    done_next   = 1'b1;
                    active_next = 1'b0;
                end
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

FILE: rtl/murmur64a_byte_hasher.sv
`timescale 1ns / 1ps

// Channel   Direction  Word layout (lowest bit first)
// s_axis    in         tdata: msg_length[31:0], data_word[95:32], word_bytes[99:96], zero pad
//                      tuser: first_word; tlast: last_word
// m_axis    out        tdata: hash_value[63:0]; tuser: short_word_error
// seed_wr   in         seed_wr_data: hash_seed, written when seed_wr_en is high
//
// Every multiplication by the mixing constant runs on one shared 32 by 32
// multiplier, one request and one answer at a time. A full word needs three
// multiplications, a tail word one and an empty word none; a first word adds
// one for the length and a last word one more for the finalizer.
// s_axis_tready is high only while the sequencer is idle, one word at a time.
// A finished hash waits in the output register, so a stall on m_axis only
// holds the block once the next hash is ready. Reset is asynchronous, active
// low; it restores the seed and clears the accumulator and the error flag.
module murmur64a_byte_hasher
(
    input  logic         clk,
    input  logic         rst_n,
    // Seed register write.
    input  logic         seed_wr_en,
    input  logic [63:0]  seed_wr_data,
    // Message words in.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // msg_length, data_word, word_bytes, pad
    input  logic         s_axis_tlast,
    input  logic [0:0]   s_axis_tuser,  // first_word
    // Hash results out.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // hash_value
    output logic [0:0]   m_axis_tuser   // short_word_error
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_LEN      = 8'b0000_0010,
        ST_DISPATCH = 8'b0000_0100,
        ST_K1       = 8'b0000_1000,
        ST_K2       = 8'b0001_0000,
        ST_HMUL     = 8'b0010_0000,
        ST_FIN      = 8'b0100_0000,
        ST_EMIT     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] seed_reg, seed_next;
    logic [63:0] h_reg, h_next;
    logic        err_reg, err_next;

    // Latched word.
    logic        last_reg, last_next;
    logic        full_reg, full_next;
    logic [2:0]  nb_reg, nb_next;
    logic [63:0] data_reg, data_next;
    logic [63:0] fin_reg, fin_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_hash_reg, out_hash_next;
    logic        out_err_reg, out_err_next;

    mm64_pkg::mul_req_t req_reg, req_next;
    mm64_pkg::mul_rsp_t rsp;

    logic [63:0] tail_mask;
    logic [63:0] tail_h;
    logic [63:0] mixed;
    logic [63:0] folded;
    logic [63:0] pre_fin;

    mm64_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (rsp)
    );

    // Keep byte i of a tail word when i is below the byte count.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            tail_mask[i*8 +: 8] = (3'(i) < nb_reg) ? 8'hff : 8'h00;
        end
    end

    assign tail_h  = h_reg ^ (data_reg & tail_mask);
    assign mixed   = rsp.result ^ (rsp.result >> mm64_pkg::MIX_SHIFT);
    assign folded  = h_reg ^ rsp.result;
    assign pre_fin = h_reg ^ (h_reg >> mm64_pkg::MIX_SHIFT);

    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_wr_en ? seed_wr_data : seed_reg;
        h_next         = h_reg;
        err_next       = err_reg;
        last_next      = last_reg;
        full_next      = full_reg;
        nb_next        = nb_reg;
        data_next      = data_reg;
        fin_next       = fin_reg;
        req_next.start   = 1'b0;
        req_next.operand = req_reg.operand;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_hash_next  = out_hash_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    last_next = s_axis_tlast;
                    // A byte count of eight or more is a full word.
                    full_next = s_axis_tdata[99];
                    nb_next   = s_axis_tdata[98:96];
                    data_next = s_axis_tdata[95:32];
                    if (s_axis_tuser[0])
                    begin
                        req_next.start   = 1'b1;
                        req_next.operand = {32'h0, s_axis_tdata[31:0]};
                        state_next       = ST_LEN;
                    end
                    else
                    begin
                        state_next = ST_DISPATCH;
                    end
                end
            end
            ST_LEN:
            begin
                if (rsp.done)
                begin
                    h_next     = seed_reg ^ rsp.result;
                    err_next   = 1'b0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (!full_reg && !last_reg)
                begin
                    err_next = 1'b1;
                end
                if (full_reg)
                begin
                    req_next.start   = 1'b1;
                    req_next.operand = data_reg;
                    state_next       = ST_K1;
                end
                else if (nb_reg != 3'd0)
                begin
                    h_next           = tail_h;
                    req_next.start   = 1'b1;
                    req_next.operand = tail_h;
                    state_next       = ST_HMUL;
                end
                else if (last_reg)
                begin
                    req_next.start   = 1'b1;
                    req_next.operand = pre_fin;
                    state_next       = ST_FIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_K1:
            begin
                if (rsp.done)
                begin
                    req_next.start   = 1'b1;
                    req_next.operand = mixed;
                    state_next       = ST_K2;
                end
            end
            ST_K2:
            begin
                if (rsp.done)
                begin
                    h_next           = folded;
                    req_next.start   = 1'b1;
                    req_next.operand = folded;
                    state_next       = ST_HMUL;
                end
            end
            ST_HMUL:
            begin
                if (rsp.done)
                begin
                    h_next = rsp.result;
                    if (last_reg)
                    begin
                        // The finalizer works on a copy; h keeps the multiplied value.
                        req_next.start   = 1'b1;
                        req_next.operand = rsp.result ^
                                           (rsp.result >> mm64_pkg::MIX_SHIFT);
                        state_next       = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN:
            begin
                if (rsp.done)
                begin
                    fin_next   = mixed;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = fin_reg;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= mm64_pkg::SEED_RESET;
            h_reg         <= 64'h0;
            err_reg       <= 1'b0;
            req_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            h_reg         <= h_next;
            err_reg       <= err_next;
            req_reg       <= req_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg         <= last_next;
        full_reg         <= full_next;
        nb_reg           <= nb_next;
        data_reg         <= data_next;
        fin_reg          <= fin_next;
        out_hash_reg     <= out_hash_next;
        out_err_reg      <= out_err_next;
    end

    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_hash_reg;
    assign m_axis_tuser[0] = out_err_reg;

endmodule

FILE: rtl/mm64_checker.sv
`timescale 1ns / 1ps

// Port-level checks of the hasher.
module mm64_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled hash changed or dropped");

    // The block works on one word at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a word was taken");

    // A hash needs at least one multiplication; it cannot follow a word at once.
    a_no_instant_hash: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("hash appeared one cycle after a word");

endmodule

bind murmur64a_byte_hasher mm64_checker u_mm64_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the streaming MurmurHash64A block. Each accepted
// input word runs through a local copy of the hash arithmetic; a word that ends
// a message leaves one expected hash and error flag in a queue. The output
// monitor compares every hash that leaves the block against the oldest entry.
module tb;

    // The slowest message word is a first, full and last word, which needs five
    // multiplications inside the block. The sender gap and the receiver stall add
    // to that. The limit below is for the whole run, not for one word.
    localparam int unsigned CYCLE_LIMIT    = 600000;
    // Cycles the block may still spend on a word that produced no hash.
    localparam int unsigned SETTLE_CYCLES  = 80;
    localparam int unsigned PHASE_WORDS    = 270;
    localparam int unsigned N_DIRECTED     = 19;

    // One input word: the two flags, then the tdata fields in interface order.
    typedef struct packed {
        logic        first_word;
        logic        last_word;
        logic [31:0] msg_length;
        logic [63:0] data_word;
        logic [3:0]  word_bytes;
    } msg_word_t;

    typedef struct packed {
        logic [63:0] hash_value;
        logic        short_err;
    } hash_result_t;

    // A directed row. The hash is typed in only where it is obvious. That is the
    // case of a message ending while the accumulator still holds its reset
    // value of zero, since the finalizer maps zero to zero.
    typedef struct packed {
        msg_word_t    stim;
        logic         typed;
        hash_result_t result;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        // No start yet: an empty last word finalizes the reset accumulator.
        '{'{1'b0, 1'b1, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 4'd0}, 1'b1, '{64'd0, 1'b0}},
        // Longest length with an all-ones full word, then a zero word and a 7-byte tail.
        '{'{1'b1, 1'b0, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 4'd8}, 1'b0, '0},
        '{'{1'b0, 1'b0, 32'h00000000, 64'h0000000000000000, 4'd8}, 1'b0, '0},
        '{'{1'b0, 1'b1, 32'h00000000, 64'h0123456789ABCDEF, 4'd7}, 1'b0, '0},
        // Start and end on one word: empty message, then one full word.
        '{'{1'b1, 1'b1, 32'h00000000, 64'h0000000000000000, 4'd0}, 1'b0, '0},
        '{'{1'b1, 1'b1, 32'h00000008, 64'hDEADBEEFCAFEF00D, 4'd8}, 1'b0, '0},
        // A short word in the middle sets the sticky error flag.
        '{'{1'b1, 1'b0, 32'h00000014, 64'h1122334455667788, 4'd3}, 1'b0, '0},
        '{'{1'b0, 1'b1, 32'h00000000, 64'h8877665544332211, 4'd8}, 1'b0, '0},
        // Byte counts above eight count as a full word.
        '{'{1'b1, 1'b1, 32'h00000008, 64'hA5A5A5A5A5A5A5A5, 4'd15}, 1'b0, '0},
        '{'{1'b1, 1'b0, 32'h00000010, 64'h5A5A5A5A5A5A5A5A, 4'd9}, 1'b0, '0},
        // An empty word before the end folds nothing but still flags an error.
        '{'{1'b0, 1'b0, 32'h00000000, 64'hFFFFFFFF00000000, 4'd0}, 1'b0, '0},
        '{'{1'b0, 1'b1, 32'h00000000, 64'h00000000000000FF, 4'd1}, 1'b0, '0},
        // Words after the end keep folding into the same accumulator.
        '{'{1'b0, 1'b0, 32'h00000000, 64'h0F0F0F0F0F0F0F0F, 4'd8}, 1'b0, '0},
        '{'{1'b0, 1'b1, 32'h00000000, 64'hF0F0F0F0F0F0F0F0, 4'd4}, 1'b0, '0},
        // A new start clears the error flag again.
        '{'{1'b1, 1'b0, 32'h00000010, 64'h0000000000000001, 4'd8}, 1'b0, '0},
        '{'{1'b0, 1'b1, 32'h00000000, 64'h8000000000000000, 4'd8}, 1'b0, '0},
        // The length does not have to match the bytes delivered.
        '{'{1'b1, 1'b1, 32'h000003E8, 64'h000000000000BEEF, 4'd2}, 1'b0, '0},
        '{'{1'b1, 1'b1, 32'h00000007, 64'hFFFFFFFFFFFFFFFF, 4'd7}, 1'b0, '0},
        '{'{1'b1, 1'b1, 32'h00000000, 64'h0000000000000000, 4'd8}, 1'b0, '0}
    };

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         seed_wr_en = 1'b0;
    logic [63:0]  seed_wr_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;    // msg_length, data_word, word_bytes, pad
    logic         s_axis_tlast = 1'b0;  // last_word
    logic [0:0]   s_axis_tuser = '0;    // first_word
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;         // hash_value
    logic [0:0]   m_axis_tuser;         // short_word_error

    murmur64a_byte_hasher uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .seed_wr_en    (seed_wr_en),
        .seed_wr_data  (seed_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Local copy of the block state: the seed register, the running accumulator
    // and the sticky flag for a short word before the end of a message.
    logic [63:0]  seed_copy = mm64_pkg::SEED_RESET;
    logic [63:0]  running_hash = '0;
    logic         short_seen = 1'b0;
    hash_result_t pending_hashes[$];
    int unsigned  fail_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  burst_left = 0;

    // Fold one accepted word into the local state. When the word ends a message,
    // this returns 1 and gives the finalized hash. The finalizer works on a copy,
    // so the accumulator keeps its value for words that follow.
    function automatic bit fold_word(input msg_word_t w, output hash_result_t r);
        logic [63:0] k;
        logic [63:0] h;
        logic [63:0] mask;
        int unsigned nb;
        nb = (w.word_bytes > 4'd8) ? 8 : w.word_bytes;
        if (w.first_word)
        begin
            running_hash = seed_copy ^ ({32'd0, w.msg_length} * mm64_pkg::MIX_MUL);
            short_seen = 1'b0;
        end
        if (nb == 8)
        begin
            k = w.data_word * mm64_pkg::MIX_MUL;
            k = k ^ (k >> mm64_pkg::MIX_SHIFT);
            k = k * mm64_pkg::MIX_MUL;
            running_hash = (running_hash ^ k) * mm64_pkg::MIX_MUL;
        end
        else
        begin
            if (nb != 0)
            begin
                mask = (64'd1 << (8 * nb)) - 64'd1;
                running_hash = (running_hash ^ (w.data_word & mask)) * mm64_pkg::MIX_MUL;
            end
            if (!w.last_word)
                short_seen = 1'b1;
        end
        h = running_hash;
        h = h ^ (h >> mm64_pkg::MIX_SHIFT);
        h = h * mm64_pkg::MIX_MUL;
        h = h ^ (h >> mm64_pkg::MIX_SHIFT);
        r.hash_value = h;
        r.short_err = short_seen;
        return w.last_word;
    endfunction

    // Offer one word and hold it until the block takes it. The sender works in
    // bursts. Between bursts, tvalid drops for a random gap, and sometimes the
    // gap is zero so that long runs go through without idling. The output arguments
    // tell the caller whether the word ended a message and give its result.
    task automatic offer_word(input msg_word_t w, output bit emits, output hash_result_t r);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, w.word_bytes, w.data_word, w.msg_length};
        s_axis_tlast <= w.last_word;
        s_axis_tuser <= w.first_word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        emits = fold_word(w, r);
    endtask

    // Offer one word and queue the predicted result if it ends a message.
    task automatic send_word(input msg_word_t w);
        bit           emits;
        hash_result_t r;
        offer_word(w, emits, r);
        if (emits)
            pending_hashes.push_back(r);
    endtask

    // End a run of stimulus. Once every hash is back, the block may still be
    // busy with a word that produced no hash, so wait a while longer.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load the seed register. This is only called while the block is idle.
    task automatic load_seed(input logic [63:0] value);
        seed_wr_en <= 1'b1;
        seed_wr_data <= value;
        @(posedge clk);
        seed_wr_en <= 1'b0;
        seed_copy = value;
    endtask

    function automatic msg_word_t random_noise_word();
        msg_word_t w;
        w.first_word = 1'($urandom_range(0, 1));
        w.last_word = 1'($urandom_range(0, 1));
        w.msg_length = $urandom;
        w.data_word = {$urandom, $urandom};
        w.word_bytes = 4'($urandom_range(0, 15));
        return w;
    endfunction

    // Mostly well-formed messages with random content and size. A message starts
    // with first_word, carries full words, and ends in a tail of 0 to 8 bytes. About
    // one message in ten picks a word to be short; that breaks it unless it is the last.
    // About one slot in ten is a random noise word instead of a message.
    task automatic run_messages(input int unsigned n_words);
        int unsigned sent;
        int unsigned n_msg_words;
        int unsigned tail_bytes;
        int unsigned broken_at;
        logic [31:0] total_len;
        msg_word_t   w;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_word(random_noise_word());
                sent++;
            end
            else
            begin
                n_msg_words = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12)
                                                         : $urandom_range(1, 4);
                tail_bytes = $urandom_range(0, 8);
                total_len = (n_msg_words - 1) * 8 + tail_bytes;
                if ($urandom_range(0, 7) == 0)
                    total_len = $urandom;
                broken_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_msg_words - 1)
                                                        : n_msg_words;
                for (int unsigned i = 0; i < n_msg_words; i++)
                begin
                    w.first_word = (i == 0);
                    w.last_word = (i == n_msg_words - 1);
                    w.msg_length = (i == 0) ? total_len : $urandom;
                    w.data_word = {$urandom, $urandom};
                    if (w.last_word)
                        w.word_bytes = 4'(tail_bytes);
                    else if (i == broken_at)
                        w.word_bytes = 4'($urandom_range(0, 7));
                    else if ($urandom_range(0, 15) == 0)
                        w.word_bytes = 4'($urandom_range(9, 15));
                    else
                        w.word_bytes = 4'd8;
                    send_word(w);
                    sent++;
                end
            end
        end
    endtask

    // Output monitor. A hash counts at an edge where tvalid and tready are both
    // high. It is compared field by field against the oldest expected result.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_hashes.size() == 0)
            begin
                $display("%0t: unexpected hash %h flag %b", $time, m_axis_tdata, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                if (m_axis_tdata !== pending_hashes[0].hash_value)
                begin
                    $display("%0t: hash_value expected %h got %h", $time,
                             pending_hashes[0].hash_value, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tuser[0] !== pending_hashes[0].short_err)
                begin
                    $display("%0t: short_word_error expected %b got %b", $time,
                             pending_hashes[0].short_err, m_axis_tuser[0]);
                    fail_count++;
                end
                void'(pending_hashes.pop_front());
            end
        end
    end

    // The receiver stalls following a 16-bit pattern that rotates every cycle. A
    // new pattern is chosen now and then. It can be always ready, random, or
    // ready only one cycle in sixteen.
    logic [15:0] ready_pattern = 16'hFFFF;
    int unsigned pattern_age = 0;

    always @(posedge clk)
    begin
        if (pattern_age == 0)
        begin
            pattern_age = $urandom_range(20, 150);
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'h0001 << $urandom_range(0, 15);
                default: ready_pattern = 16'($urandom) | 16'h0001;
            endcase
        end
        pattern_age--;
        m_axis_tready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    // Watchdog for a block that hangs or loses a hash.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d hashes outstanding", $time, pending_hashes.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        bit           emits;
        hash_result_t r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words with the seed still at its reset value.
        for (int unsigned i = 0; i < N_DIRECTED; i++)
        begin
            offer_word(DIRECTED_ROWS[i].stim, emits, r);
            if (emits)
                pending_hashes.push_back(DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].result : r);
        end
        drain_block();

        // Random phases. Each one runs under its own seed: the two extremes
        // first, then random values.
        for (int unsigned phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: load_seed(64'd0);
                1: load_seed('1);
                default: load_seed({$urandom, $urandom});
            endcase
            run_messages(PHASE_WORDS);
            drain_block();
        end

        if (fail_count == 0 && pending_hashes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
